>>> rtl/m3i_pkg.sv
// Package for the 3x3 matrix inverse core: payload types, sizes and cofactor index tables.
package m3i_pkg;

    // element format
    localparam int EW         = 16;
    localparam int FB_DEF     = 12;
    localparam int OUT_FRAC   = 16;
    localparam int OUT_W      = 32;
    // quotient bits per element: 32 result bits plus one rounding bit
    localparam int QB         = OUT_W + 1;

    // derived widths of the exact arithmetic
    localparam int PW         = 2 * EW;        // element product
    localparam int CW         = 2 * EW + 1;    // adjugate entry
    localparam int DPW        = EW + CW;       // determinant partial product
    localparam int DW         = 3 * EW + 3;    // determinant

    // adjugate entry k = a[P]*a[Q] - a[R]*a[S], row-major element order
    localparam int COF_P [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int COF_Q [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int COF_R [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int COF_S [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef struct packed {
        logic signed [EW-1:0] a11;
        logic signed [EW-1:0] a12;
        logic signed [EW-1:0] a13;
        logic signed [EW-1:0] a21;
        logic signed [EW-1:0] a22;
        logic signed [EW-1:0] a23;
        logic signed [EW-1:0] a31;
        logic signed [EW-1:0] a32;
        logic signed [EW-1:0] a33;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] r11;
        logic signed [OUT_W-1:0] r12;
        logic signed [OUT_W-1:0] r13;
        logic signed [OUT_W-1:0] r21;
        logic signed [OUT_W-1:0] r22;
        logic signed [OUT_W-1:0] r23;
        logic signed [OUT_W-1:0] r31;
        logic signed [OUT_W-1:0] r32;
        logic signed [OUT_W-1:0] r33;
        logic                    singular;
    } t_out;

endpackage

>>> rtl/m3i_div.sv
// Pipelined restoring divider, one quotient bit per stage, with rounding and saturation.
module m3i_div import m3i_pkg::*; #(
    parameter int DVW = DW
) (
    input  logic                    i_clk,
    input  logic [QB-1:0]           i_en,
    input  logic [DVW-1:0]          i_rem,
    input  logic [QB-1:0]           i_num,
    input  logic [DVW-1:0]          i_den,
    input  logic                    i_neg,
    input  logic                    i_ovf,
    output logic signed [OUT_W-1:0] o_res
);

    typedef struct packed {
        logic [DVW-1:0] rem;
        logic [DVW-1:0] den;
        logic [QB-1:0]  num;
        logic [QB-1:0]  q;
        logic           neg;
        logic           ovf;
    } t_dst;

    t_dst r_st [QB];

    genvar j;
    generate
        for (j = 0; j < QB; j++) begin : g_stage
            t_dst         w_prev;
            t_dst         n_st;
            logic [DVW:0] w_t;
            logic         w_ge;

            if (j == 0) begin : g_first
                assign w_prev = '{rem: i_rem, den: i_den, num: i_num, q: '0,
                                  neg: i_neg, ovf: i_ovf};
            end else begin : g_next
                assign w_prev = r_st[j-1];
            end

            // bring down the next dividend bit, subtract if it fits
            always_comb begin
                w_t         = {w_prev.rem, w_prev.num[QB-1]};
                w_ge        = (w_t >= {1'b0, w_prev.den});
                n_st        = w_prev;
                n_st.rem    = w_ge ? DVW'(w_t - {1'b0, w_prev.den}) : DVW'(w_t);
                n_st.num    = {w_prev.num[QB-2:0], 1'b0};
                n_st.q      = {w_prev.q[QB-2:0], w_ge};
            end

            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_st[j] <= n_st;
                end
            end
        end
    endgenerate

    // round half away from zero on the magnitude, then sign and saturate
    logic [QB-1:0] w_mag;
    assign w_mag = {1'b0, r_st[QB-1].q[QB-1:1]} + QB'(r_st[QB-1].q[0]);

    always_comb begin
        if (r_st[QB-1].neg) begin
            if (r_st[QB-1].ovf || (w_mag >= QB'(33'h0_8000_0000))) begin
                o_res = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                o_res = OUT_W'(-w_mag);
            end
        end else begin
            if (r_st[QB-1].ovf || (w_mag > QB'(33'h0_7FFF_FFFF))) begin
                o_res = {1'b0, {(OUT_W-1){1'b1}}};
            end else begin
                o_res = OUT_W'(w_mag);
            end
        end
    end

endmodule

>>> rtl/matrix3_inverse_core.sv
// Top level of the 3x3 matrix inverse core: exact adjugate and determinant, pipelined division.
//
//  channel | valid   | ready   | payload | item
//  --------+---------+---------+---------+-------------------------------------
//  input   | i_valid | o_ready | i_data  | nine signed Q4.12 elements
//  output  | o_valid | i_ready | o_data  | nine signed Q16.16 results, singular
//
//  One item per cycle while the output is not stalled; 6 input and arithmetic stages,
//  33 divider stages for 32 result bits plus a rounding bit, 1 output stage.
//  The divider chain sets the depth: one quotient bit per stage.
//  Reset (synchronous, active low) clears the valid bits only.
//  Each stage holds only while its successor is full and stalled, so bubbles
//  close up and a new item is taken while a result waits, if any stage is empty.
module matrix3_inverse_core import m3i_pkg::*; #(
    parameter int FRACTION_BITS = FB_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int SH  = FRACTION_BITS + OUT_FRAC + 1;
    localparam int XW  = CW + SH;
    localparam int MW  = (XW > DW) ? XW : DW;
    localparam int DV0 = 6;
    localparam int NS  = DV0 + QB + 1;

    // stage valids and per-stage load enables
    logic [NS-1:0] r_v;
    logic [NS:0]   w_en;

    assign w_en[NS] = i_ready;
    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_en
            assign w_en[s] = !r_v[s] || w_en[s+1];
        end
    endgenerate

    assign o_ready = w_en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int m = 1; m < NS; m++) begin
                if (w_en[m]) begin
                    r_v[m] <= r_v[m-1];
                end
            end
        end
    end

    // stage 0: input register
    t_in r_in;
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_in <= i_data;
        end
    end

    logic signed [EW-1:0] w_a [9];
    assign w_a[0] = r_in.a11;
    assign w_a[1] = r_in.a12;
    assign w_a[2] = r_in.a13;
    assign w_a[3] = r_in.a21;
    assign w_a[4] = r_in.a22;
    assign w_a[5] = r_in.a23;
    assign w_a[6] = r_in.a31;
    assign w_a[7] = r_in.a32;
    assign w_a[8] = r_in.a33;

    // stage 1: the eighteen element products
    logic signed [PW-1:0] r_p1 [9];
    logic signed [PW-1:0] r_p2 [9];
    logic signed [EW-1:0] r_row1 [3];
    // stage 2: adjugate entries
    logic signed [CW-1:0] r_c2 [9];
    logic signed [EW-1:0] r_row2 [3];
    // stage 3: determinant partial products
    logic signed [DPW-1:0] r_dp [3];
    logic signed [CW-1:0]  r_c3 [9];
    // stage 4: determinant
    logic signed [DW-1:0]  r_det;
    logic signed [CW-1:0]  r_c4 [9];
    // stage 5: divider set-up
    logic [DW-1:0]         r_rem0 [9];
    logic [QB-1:0]         r_num  [9];
    logic                  r_neg  [9];
    logic                  r_ovf  [9];
    logic [DW-1:0]         r_den;
    logic                  r_sing5;

    genvar k;
    generate
        for (k = 0; k < 9; k++) begin : g_cof
            always_ff @(posedge i_clk) begin
                if (w_en[1]) begin
                    r_p1[k] <= w_a[COF_P[k]] * w_a[COF_Q[k]];
                    r_p2[k] <= w_a[COF_R[k]] * w_a[COF_S[k]];
                end
                if (w_en[2]) begin
                    r_c2[k] <= CW'(r_p1[k]) - CW'(r_p2[k]);
                end
                if (w_en[3]) begin
                    r_c3[k] <= r_c2[k];
                end
                if (w_en[4]) begin
                    r_c4[k] <= r_c3[k];
                end
            end
        end
        for (k = 0; k < 3; k++) begin : g_row
            always_ff @(posedge i_clk) begin
                if (w_en[1]) begin
                    r_row1[k] <= w_a[k];
                end
                if (w_en[2]) begin
                    r_row2[k] <= r_row1[k];
                end
                // expansion along the first row: a1j times cofactor of column j
                if (w_en[3]) begin
                    r_dp[k] <= r_row2[k] * r_c2[3*k];
                end
            end
        end
    endgenerate

    // determinant sum
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_det <= DW'(r_dp[0]) + DW'(r_dp[1]) + DW'(r_dp[2]);
        end
    end

    // magnitudes, signs, overflow check and first partial remainder
    logic [DW-1:0] w_dabs;
    assign w_dabs = r_det[DW-1] ? DW'(-r_det) : DW'(r_det);

    generate
        for (k = 0; k < 9; k++) begin : g_prep
            logic [CW-1:0] w_cabs;
            logic [XW-1:0] w_n2;
            logic [XW-1:0] w_hi;
            assign w_cabs = r_c4[k][CW-1] ? CW'(-r_c4[k]) : CW'(r_c4[k]);
            assign w_n2   = {w_cabs, {SH{1'b0}}};
            assign w_hi   = w_n2 >> QB;
            always_ff @(posedge i_clk) begin
                if (w_en[5]) begin
                    r_rem0[k] <= DW'(w_hi);
                    r_num[k]  <= w_n2[QB-1:0];
                    r_neg[k]  <= r_c4[k][CW-1] ^ r_det[DW-1];
                    r_ovf[k]  <= (MW'(w_hi) >= MW'(w_dabs));
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_den   <= w_dabs;
            r_sing5 <= (r_det == '0);
        end
    end

    // dividers, one per result element
    logic signed [OUT_W-1:0] w_res [9];
    generate
        for (k = 0; k < 9; k++) begin : g_div
            m3i_div #(.DVW(DW)) u_div (
                .i_clk (i_clk),
                .i_en  (w_en[DV0 +: QB]),
                .i_rem (r_rem0[k]),
                .i_num (r_num[k]),
                .i_den (r_den),
                .i_neg (r_neg[k]),
                .i_ovf (r_ovf[k]),
                .o_res (w_res[k])
            );
        end
    endgenerate

    // singular flag rides alongside the divider stages
    logic [QB-1:0] r_sing;
    always_ff @(posedge i_clk) begin
        if (w_en[DV0]) begin
            r_sing[0] <= r_sing5;
        end
        for (int j = 1; j < QB; j++) begin
            if (w_en[DV0+j]) begin
                r_sing[j] <= r_sing[j-1];
            end
        end
    end

    // output register; a singular matrix gives all zeros
    t_out r_out;
    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_out.r11      <= r_sing[QB-1] ? '0 : w_res[0];
            r_out.r12      <= r_sing[QB-1] ? '0 : w_res[1];
            r_out.r13      <= r_sing[QB-1] ? '0 : w_res[2];
            r_out.r21      <= r_sing[QB-1] ? '0 : w_res[3];
            r_out.r22      <= r_sing[QB-1] ? '0 : w_res[4];
            r_out.r23      <= r_sing[QB-1] ? '0 : w_res[5];
            r_out.r31      <= r_sing[QB-1] ? '0 : w_res[6];
            r_out.r32      <= r_sing[QB-1] ? '0 : w_res[7];
            r_out.r33      <= r_sing[QB-1] ? '0 : w_res[8];
            r_out.singular <= r_sing[QB-1];
        end
    end

    assign o_data = r_out;

endmodule

>>> rtl/m3i_checker.sv
// Port checker for the 3x3 matrix inverse core, with its bind.
module m3i_checker import m3i_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data))
        else $error("result changed while stalled");

    // singular results are all zero
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.singular |->
            o_data.r11 == '0 && o_data.r12 == '0 && o_data.r13 == '0 &&
            o_data.r21 == '0 && o_data.r22 == '0 && o_data.r23 == '0 &&
            o_data.r31 == '0 && o_data.r32 == '0 && o_data.r33 == '0)
        else $error("singular item with non-zero result");

    // nothing comes out straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // an empty output slot never holds off the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input refused with output empty");

endmodule

bind matrix3_inverse_core m3i_checker u_m3i_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

>>> tb/matrix3_inverse_core_chk.sv
// Checker for the 3x3 matrix inverse core: predicts each inverse and compares results.
module matrix3_inverse_core_chk import m3i_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic o_ready,
    input  t_in  i_data,
    input  logic o_valid,
    input  logic i_ready,
    input  t_out o_data,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCALE = FB_DEF + OUT_FRAC;

    t_out inverse_q[$];

    // rounded, saturated quotient c * 2^SCALE / d, d non-zero
    function automatic logic [OUT_W-1:0] scaled_ratio(longint c, longint d);
        longint unsigned num, den, q, rem;
        logic            neg;
        neg = (c < 0) != (d < 0);
        num = (c < 0) ? -c : c;
        den = (d < 0) ? -d : d;
        num = num << SCALE;
        q   = num / den;
        rem = num % den;
        if (2 * rem >= den) q = q + 1;
        if (neg) begin
            if (q >= 64'h8000_0000) return 32'h8000_0000;
            return -q[OUT_W-1:0];
        end
        if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return q[OUT_W-1:0];
    endfunction

    function automatic t_out predict_inverse(t_in m);
        longint a [9];
        longint adj [9];
        longint det;
        t_out   r;
        a = '{longint'(m.a11), longint'(m.a12), longint'(m.a13),
              longint'(m.a21), longint'(m.a22), longint'(m.a23),
              longint'(m.a31), longint'(m.a32), longint'(m.a33)};
        // adjugate, row-major
        adj[0] = a[4]*a[8] - a[5]*a[7];
        adj[1] = a[2]*a[7] - a[1]*a[8];
        adj[2] = a[1]*a[5] - a[2]*a[4];
        adj[3] = a[5]*a[6] - a[3]*a[8];
        adj[4] = a[0]*a[8] - a[2]*a[6];
        adj[5] = a[2]*a[3] - a[0]*a[5];
        adj[6] = a[3]*a[7] - a[4]*a[6];
        adj[7] = a[1]*a[6] - a[0]*a[7];
        adj[8] = a[0]*a[4] - a[1]*a[3];
        det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        r.r11 = scaled_ratio(adj[0], det);
        r.r12 = scaled_ratio(adj[1], det);
        r.r13 = scaled_ratio(adj[2], det);
        r.r21 = scaled_ratio(adj[3], det);
        r.r22 = scaled_ratio(adj[4], det);
        r.r23 = scaled_ratio(adj[5], det);
        r.r31 = scaled_ratio(adj[6], det);
        r.r32 = scaled_ratio(adj[7], det);
        r.r33 = scaled_ratio(adj[8], det);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    task automatic compare_inverse(t_out got, t_out want);
        if (got.r11 != want.r11) report_mismatch("r11", got.r11, want.r11);
        if (got.r12 != want.r12) report_mismatch("r12", got.r12, want.r12);
        if (got.r13 != want.r13) report_mismatch("r13", got.r13, want.r13);
        if (got.r21 != want.r21) report_mismatch("r21", got.r21, want.r21);
        if (got.r22 != want.r22) report_mismatch("r22", got.r22, want.r22);
        if (got.r23 != want.r23) report_mismatch("r23", got.r23, want.r23);
        if (got.r31 != want.r31) report_mismatch("r31", got.r31, want.r31);
        if (got.r32 != want.r32) report_mismatch("r32", got.r32, want.r32);
        if (got.r33 != want.r33) report_mismatch("r33", got.r33, want.r33);
        if (got.singular != want.singular)
            report_mismatch("singular", got.singular, want.singular);
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // watch both channels at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) inverse_q.push_back(predict_inverse(i_data));
            if (o_valid && i_ready) begin
                if (inverse_q.size() == 0) report_mismatch("unexpected item", 1, 0);
                else compare_inverse(o_data, inverse_q.pop_front());
            end
            o_pending = inverse_q.size();
        end
    end

    function automatic int leftover();
        return inverse_q.size();
    endfunction
endmodule

>>> tb/matrix3_inverse_core_tb.sv
// Testbench top for the 3x3 matrix inverse core: stimulus, handshake pressure and verdict.
module matrix3_inverse_core_tb;
    import m3i_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 40;
    localparam logic signed [EW-1:0] ONE  = 16'sd4096;
    localparam logic signed [EW-1:0] EMAX = 16'sh7FFF;
    localparam logic signed [EW-1:0] EMIN = 16'sh8000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data = '0;
    logic o_ready, o_valid;
    t_out o_data;
    int   mismatches, in_flight;
    int   cyc = 0;

    matrix3_inverse_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    matrix3_inverse_core_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .o_errors(mismatches), .o_pending(in_flight)
    );

    always #5 i_clk = ~i_clk;

    // receiver: one long hold-off, calm stretches, random stalls otherwise
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= 400 && cyc < 700) i_ready <= 1'b0;
        else if ((cyc / 600) % 3 == 0) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 3) != 0);
    end

    function automatic t_in mk(int v0, int v1, int v2, int v3, int v4,
                               int v5, int v6, int v7, int v8);
        t_in m;
        m.a11 = EW'(v0); m.a12 = EW'(v1); m.a13 = EW'(v2);
        m.a21 = EW'(v3); m.a22 = EW'(v4); m.a23 = EW'(v5);
        m.a31 = EW'(v6); m.a32 = EW'(v7); m.a33 = EW'(v8);
        return m;
    endfunction

    // offer one matrix and hold it until taken
    task automatic send_matrix(t_in m);
        i_valid <= 1'b1;
        i_data  <= m;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [EW-1:0] rnd_elem(int kind);
        case (kind)
            0: return EW'($urandom());
            1: return EW'($signed($urandom_range(0, 16383)) - 8192);
            2: return EW'($signed($urandom_range(0, 255)) - 128);
            default: return ($urandom_range(0, 1)) ? EMAX : EMIN;
        endcase
    endfunction

    function automatic t_in rnd_matrix();
        t_in m;
        int  kind, shape;
        kind  = $urandom_range(0, 9);
        kind  = (kind < 4) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3;
        shape = $urandom_range(0, 9);
        m = {rnd_elem(kind), rnd_elem(kind), rnd_elem(kind),
             rnd_elem(kind), rnd_elem(kind), rnd_elem(kind),
             rnd_elem(kind), rnd_elem(kind), rnd_elem(kind)};
        if (shape == 0) begin
            // repeated row: singular with non-zero entries
            m.a31 = m.a11; m.a32 = m.a12; m.a33 = m.a13;
        end else if (shape == 1) begin
            // diagonal set near one, other entries as drawn
            m.a11 = ONE + rnd_elem(2); m.a22 = ONE + rnd_elem(2);
            m.a33 = ONE + rnd_elem(2);
        end else if (shape == 2) begin
            // near-singular: tiny determinant, large inverse
            m.a21 = m.a11 + EW'($signed($urandom_range(0, 2)) - 1);
            m.a22 = m.a12; m.a23 = m.a13;
        end
        return m;
    endfunction

    initial begin
        t_in directed [$];
        int  burst;
        directed = '{
            mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE),
            mk(0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(EMAX, 0, 0, 0, EMAX, 0, 0, 0, EMAX),
            mk(EMIN, 0, 0, 0, EMIN, 0, 0, 0, EMIN),
            mk(EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMIN),
            mk(1, 0, 0, 0, 1, 0, 0, 0, 1),
            mk(-1, 0, 0, 0, 1, 0, 0, 0, 1),
            mk(EMAX, EMIN, 0, EMIN, EMAX, 0, 0, 0, 1),
            mk(EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN),
            mk(EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX),
            mk(1, 2, 3, 4, 5, 6, 7, 8, 9),
            mk(0, ONE, 0, 0, 0, ONE, ONE, 0, 0),
            mk(2*ONE, 0, 0, 0, -ONE, 0, 0, 0, 3*ONE),
            mk(3, 0, 0, 0, 3, 0, 0, 0, 3),
            mk(-1, -1, -1, -1, -1, -1, -1, -1, -1),
            mk(16'sh5555, 16'sh2AAA, 0, 0, 16'sh5555, 16'sh2AAA, 16'sh2AAA, 0, 16'sh5555)
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) send_matrix(directed[k]);
        for (int n = 0; n < 1500; n++) begin
            if (n == 700) begin
                // drain completely before carrying on
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (in_flight != 0) @(posedge i_clk);
            end
            send_matrix(rnd_matrix());
            burst = burst - 1;
            if (burst <= 0) begin
                burst = $urandom_range(1, 30);
                idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
            end
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (in_flight != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && chk.leftover() == 0)
            $display("matrix3_inverse_core_tb OK");
        else
            $display("matrix3_inverse_core_tb NOT OK");
        $finish;
    end

    initial begin
        #5ms;
        $display("matrix3_inverse_core_tb NOT OK");
        $finish;
    end
endmodule

>>> sim.f
rtl/m3i_pkg.sv
rtl/m3i_div.sv
rtl/matrix3_inverse_core.sv
rtl/m3i_checker.sv
tb/matrix3_inverse_core_chk.sv
tb/matrix3_inverse_core_tb.sv
